// File: hw/rtl/b36_pkg.sv
// ----------------------------------------------------------------------------
// b36_pkg: shared types and constants for the base-36 text parser
// Character codes, limits, status codes and the structs that pass between
// the digit decoder, the accumulator and the top level.
// ----------------------------------------------------------------------------
package b36_pkg;

    // Widths of the channel fields
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 63;
    localparam int STATUS_W = 3;
    localparam int DIGIT_W  = 6;
    localparam int COUNT_W  = 4;

    // Longest string accepted, in characters
    localparam logic [COUNT_W-1:0] MAX_DIGITS = 4'd13;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ  = 8'h7A;

    // Offsets that map a letter to its digit value (letter - 'A' + 10)
    localparam logic [CHAR_W-1:0] UPPER_OFS = 8'd55;
    localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd87;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // Decoded character
    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    // Result of one string
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: hw/rtl/b36_digit_dec.sv
// ----------------------------------------------------------------------------
// b36_digit_dec: base-36 digit decoder
// Maps an ASCII byte to its digit value 0-35 and flags bytes that are not
// digits.
// ----------------------------------------------------------------------------
module b36_digit_dec (
    input  logic [b36_pkg::CHAR_W-1:0] char_code,
    output b36_pkg::digit_t            dec
);
    import b36_pkg::*;

    logic [CHAR_W-1:0] diff;

    // Select range and subtract its offset
    always_comb begin
        diff         = '0;
        dec.is_digit = 1'b0;
        if (char_code inside {[CH_0:CH_9]}) begin
            diff         = char_code - CH_0;
            dec.is_digit = 1'b1;
        end else if (char_code inside {[CH_UA:CH_UZ]}) begin
            diff         = char_code - UPPER_OFS;
            dec.is_digit = 1'b1;
        end else if (char_code inside {[CH_LA:CH_LZ]}) begin
            diff         = char_code - LOWER_OFS;
            dec.is_digit = 1'b1;
        end
        dec.digit = diff[DIGIT_W-1:0];
    end

endmodule

// File: hw/rtl/b36_accum.sv
// ----------------------------------------------------------------------------
// b36_accum: base-36 accumulator and status logic
// Holds the running value, the character count and the error flags, updates
// them once per character and forms the result for the terminating byte.
// ----------------------------------------------------------------------------
module b36_accum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [b36_pkg::CHAR_W-1:0] char_code,
    output b36_pkg::result_t           result
);
    import b36_pkg::*;

    localparam int PROD_W = VALUE_W + DIGIT_W;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               too_long_reg, too_long_next;
    logic               bad_reg, bad_next;
    logic               ovf_reg, ovf_next;

    digit_t             dec;
    logic [PROD_W-1:0]  prod;
    logic               is_term;

    b36_digit_dec u_dec (
        .char_code (char_code),
        .dec       (dec)
    );

    assign is_term = (char_code == CH_NUL);

    // Times 36 as two shifts plus the new digit; anything above bit 62 overflows
    assign prod = ({{DIGIT_W{1'b0}}, acc_reg} << 5)
                + ({{DIGIT_W{1'b0}}, acc_reg} << 2)
                + {{VALUE_W{1'b0}}, dec.digit};

    // Advance state on each character, clear it on the terminator
    always_comb begin
        acc_next      = acc_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        bad_next      = bad_reg;
        ovf_next      = ovf_reg;
        if (step) begin
            if (is_term) begin
                acc_next      = '0;
                count_next    = '0;
                too_long_next = 1'b0;
                bad_next      = 1'b0;
                ovf_next      = 1'b0;
            end else if (count_reg >= MAX_DIGITS) begin
                too_long_next = 1'b1;
            end else begin
                count_next = count_reg + COUNT_W'(1);
                if (!dec.is_digit) begin
                    bad_next = 1'b1;
                end else if (!bad_reg && !ovf_reg) begin
                    if (prod[PROD_W-1:VALUE_W] != '0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[VALUE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            bad_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
            bad_reg      <= bad_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Pick status by precedence; value only on success
    always_comb begin
        result.value = '0;
        if (too_long_reg) begin
            result.status = ST_TOO_LONG;
        end else if (count_reg == '0) begin
            result.status = ST_EMPTY;
        end else if (bad_reg) begin
            result.status = ST_BAD_DIGIT;
        end else if (ovf_reg) begin
            result.status = ST_RANGE;
        end else begin
            result.status = ST_OK;
            result.value  = acc_reg;
        end
    end

endmodule

// File: hw/rtl/base36_text_to_integer_core.sv
// ----------------------------------------------------------------------------
// base36_text_to_integer_core: base-36 string to 63-bit integer parser
// A terminating byte's result passes the input register and then the output
// register before it is presented; a full result slot can hold it in between.
// Throughput: one byte per cycle, but a terminator waits while the result slot
// is full. Characters other than the terminator give no result.
// Reset (aresetn low, synchronous) clears the accumulator, count, flags and
// both channel valid flags.
// ----------------------------------------------------------------------------
module base36_text_to_integer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [b36_pkg::CHAR_W-1:0]   s_char_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [b36_pkg::VALUE_W-1:0]  m_value,
    output logic [b36_pkg::STATUS_W-1:0] m_status
);
    import b36_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic    res_free;
    logic    is_term;
    logic    step;
    result_t result;

    // A byte moves on unless it is a terminator and the result slot is full
    assign res_free = !out_valid_reg || m_ready;
    assign is_term  = (in_char_reg == CH_NUL);
    assign step     = in_valid_reg && (!is_term || res_free);
    assign s_ready  = !in_valid_reg || step;

    b36_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (in_char_reg),
        .result    (result)
    );

    // Hold the input byte until it is consumed
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    // Load a result on the terminator, drop it once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (step && is_term) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
        end
        if (step && is_term) begin
            out_reg <= result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_reg.value;
    assign m_status = out_reg.status;

endmodule
